>>> rtl/core/sghm_pkg.sv
package sghm_pkg;

  localparam int SEQ_BITS = 14;
  localparam int LEN_BITS = 16;
  localparam int BIN_IDX_BITS = 8;
  localparam int CNT_BITS = 32;
  localparam int STREAM_COUNT_DEF = 4;
  localparam int BIN_COUNT_DEF = 256;
  localparam int CFG_DATA_BITS = 16;
  localparam int IN_DATA_BITS = 40;
  localparam int IN_USER_BITS = 4;
  localparam int OUT_DATA_BITS = 152;
  localparam int OUT_FIFO_DEPTH = 4;

  localparam logic [LEN_BITS-1:0] FULL_LEN_SCIENCE_RST = 16'd952;
  localparam logic [LEN_BITS-1:0] FULL_LEN_HK_RST = 16'd192;
  localparam logic [SEQ_BITS-1:0] LARGE_GAP = 14'd255;

  typedef enum logic [0:0] {
    REG_FULL_LEN_SCIENCE = 1'b0,
    REG_FULL_LEN_HK      = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_RECORD     = 2'd0,
    MODE_BIN_READ   = 2'd1,
    MODE_COUNT_READ = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CLASS_HOUSEKEEPING = 2'd0,
    CLASS_LOW_RATE     = 2'd1,
    CLASS_HIGH_RATE    = 2'd2,
    CLASS_OTHER        = 2'd3
  } stream_class_t;

  typedef struct packed {
    logic signed [CNT_BITS-1:0] expected_count;
    logic [CNT_BITS-1:0]        fill_count;
    logic [CNT_BITS-1:0]        full_count;
    logic [CNT_BITS-1:0]        bin_total;
    logic                       large_gap;
    logic [SEQ_BITS-1:0]        gap_length;
    logic                       gap_found;
    logic                       first_seen;
  } result_t;

endpackage

>>> rtl/core/sequence_gap_histogram_monitor_core.sv
// Sequence gap histogram monitor.
// Input channel s_axis: one transfer per packet header or read request. tuser
// selects the operation (record a packet, read a histogram bin, read class
// counts) and the stream class; tdata carries sequence count, data length and
// bin index. Output channel m_axis: exactly one result transfer per input
// transfer, in order. cfg_write/cfg_index/cfg_data set the full-packet lengths
// and take effect at the next accepted item.
// Throughput is one item per cycle while s_axis_tready is high. The histogram
// lives in a single RAM with a registered read: the bin is read in the accept
// cycle and updated in the next one, with the previous cycle's write forwarded
// so back-to-back hits on one bin see fresh data. Per-class state sits in registers.
// Each result is registered in the bin read stage (s1) and then written into
// the output queue, from which m_axis presents it.
// After reset the histogram RAM is cleared one entry per cycle, covering all
// STREAM_COUNT*BIN_COUNT entries (1024 by default); s_axis_tready stays low
// until that pass ends. Config writes are taken during it.
// A four-entry output queue holds results while m_axis_tready is low;
// s_axis_tready drops once the queue can take no more in-flight results.
module sequence_gap_histogram_monitor_core #(
  parameter int STREAM_COUNT = sghm_pkg::STREAM_COUNT_DEF,
  parameter int BIN_COUNT = sghm_pkg::BIN_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [0:0]                         cfg_index,
  input  logic [sghm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sequence_req, data_length, bin_index, zero pad
  input  logic [sghm_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // mode, stream_class
  input  logic [sghm_pkg::IN_USER_BITS-1:0]  s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // first_seen, gap_found, gap_length, large_gap, bin_total, full_count,
  // fill_count, expected_count, zero pad
  output logic [sghm_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int DEPTH = STREAM_COUNT * BIN_COUNT;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int SB = sghm_pkg::SEQ_BITS;
  localparam int NB = sghm_pkg::CNT_BITS;
  localparam int LB = sghm_pkg::LEN_BITS;
  localparam int QW = $clog2(sghm_pkg::OUT_FIFO_DEPTH);
  localparam int PAD = sghm_pkg::OUT_DATA_BITS - $bits(sghm_pkg::result_t);

  typedef struct packed {
    logic                       valid;
    logic                       bin_read;
    logic                       bin_write;
    logic [AW-1:0]              addr;
    logic [SB-1:0]              gap;
    logic                       first_seen;
    logic                       gap_found;
    logic                       large_gap;
    logic [NB-1:0]              full_count;
    logic [NB-1:0]              fill_count;
    logic signed [NB-1:0]       expected_count;
  } stage_t;

  logic [LB-1:0] full_len_science;
  logic [LB-1:0] full_len_hk;

  logic          seen     [STREAM_COUNT];
  logic [SB-1:0] first_seq[STREAM_COUNT];
  logic [SB-1:0] last_seq [STREAM_COUNT];
  logic [NB-1:0] rollover [STREAM_COUNT];
  logic [NB-1:0] full_cnt [STREAM_COUNT];
  logic [NB-1:0] fill_cnt [STREAM_COUNT];

  logic          clearing;
  logic [AW-1:0] clr_addr;

  stage_t s1;
  stage_t s1_next;

  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  logic [NB-1:0] wb_data;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [NB-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [NB-1:0] ram_rdata;

  sghm_pkg::result_t fifo[sghm_pkg::OUT_FIFO_DEPTH];
  logic [QW-1:0]     wr_ptr;
  logic [QW-1:0]     rd_ptr;
  logic [QW:0]       count;
  sghm_pkg::result_t s1_result;

  sghm_pkg::mode_t          mode;
  sghm_pkg::stream_class_t  cls;
  logic                     cls_ok;
  logic [CW-1:0]            cls_idx;
  logic [SB-1:0]            seq;
  logic [LB-1:0]            len;
  logic [sghm_pkg::BIN_IDX_BITS-1:0] bin_idx;
  logic                     accept;
  logic                     rec;
  logic                     first;
  logic [SB-1:0]            prev_last;
  logic [SB-1:0]            seq_expect;
  logic [SB-1:0]            gap;
  logic                     gap_hit;
  logic [SB-1:0]            bin_sel;
  logic                     count_full;
  logic                     count_fill;
  logic                     is_full;
  logic [NB:0]              roll_sum;
  logic signed [NB+2:0]     e_sum;
  logic [NB-1:0]            bin_old;
  logic [NB:0]              bin_sum;
  logic                     pop;

  assign mode    = sghm_pkg::mode_t'(s_axis_tuser[1:0]);
  assign cls     = sghm_pkg::stream_class_t'(s_axis_tuser[3:2]);
  assign cls_ok  = 32'(s_axis_tuser[3:2]) < 32'(STREAM_COUNT);
  assign cls_idx = cls_ok ? CW'(s_axis_tuser[3:2]) : '0;
  assign seq     = s_axis_tdata[SB-1:0];
  assign len     = s_axis_tdata[SB+LB-1:SB];
  assign bin_idx = s_axis_tdata[SB+LB+sghm_pkg::BIN_IDX_BITS-1:SB+LB];

  assign s_axis_tready = !clearing && (count < (QW+1)'(sghm_pkg::OUT_FIFO_DEPTH - 1));
  assign accept = s_axis_tvalid && s_axis_tready;
  assign rec = accept && cls_ok && (mode == sghm_pkg::MODE_RECORD);

  assign first      = !seen[cls_idx];
  assign prev_last  = last_seq[cls_idx];
  assign seq_expect = prev_last + SB'(1);
  assign gap        = seq - seq_expect;
  assign gap_hit    = !first && (seq_expect != seq);
  assign bin_sel    = (32'(gap) < 32'(BIN_COUNT - 1)) ? gap : SB'(BIN_COUNT - 1);
  assign roll_sum   = {1'b0, rollover[cls_idx]} + (NB+1)'(2 ** SB);

  always_comb begin
    count_full = 1'b0;
    count_fill = 1'b0;
    is_full    = 1'b0;
    case (cls)
      sghm_pkg::CLASS_HOUSEKEEPING: begin
        is_full    = (len == full_len_hk);
        count_full = is_full;
        count_fill = !is_full;
      end
      sghm_pkg::CLASS_LOW_RATE, sghm_pkg::CLASS_HIGH_RATE: begin
        is_full    = (len == full_len_science);
        count_full = is_full;
        count_fill = !is_full;
      end
      default: begin
        count_full = 1'b0;
        count_fill = 1'b0;
      end
    endcase
  end

  assign e_sum = $signed({{(NB+3-SB){1'b0}}, last_seq[cls_idx]})
               - $signed({{(NB+3-SB){1'b0}}, first_seq[cls_idx]})
               + $signed({3'b000, rollover[cls_idx]});

  always_comb begin
    s1_next = '0;
    s1_next.valid = accept;
    ram_raddr = '0;
    if (cls_ok) begin
      case (mode)
        sghm_pkg::MODE_RECORD: begin
          ram_raddr = AW'(32'(cls_idx) * BIN_COUNT + 32'(bin_sel));
          s1_next.addr       = ram_raddr;
          s1_next.bin_write  = gap_hit;
          s1_next.gap        = gap_hit ? gap : '0;
          s1_next.first_seen = first;
          s1_next.gap_found  = gap_hit;
          s1_next.large_gap  = gap_hit && (gap >= sghm_pkg::LARGE_GAP);
        end
        sghm_pkg::MODE_BIN_READ: begin
          ram_raddr = AW'(32'(cls_idx) * BIN_COUNT + 32'(bin_idx));
          s1_next.addr     = ram_raddr;
          s1_next.bin_read = 32'(bin_idx) < 32'(BIN_COUNT);
        end
        sghm_pkg::MODE_COUNT_READ: begin
          s1_next.full_count = full_cnt[cls_idx];
          s1_next.fill_count = fill_cnt[cls_idx];
          if (e_sum > $signed((NB+3)'(32'h7fff_ffff))) begin
            s1_next.expected_count = 32'sh7fff_ffff;
          end else begin
            s1_next.expected_count = e_sum[NB-1:0];
          end
        end
        default: begin
          s1_next.valid = accept;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_len_science <= sghm_pkg::FULL_LEN_SCIENCE_RST;
      full_len_hk      <= sghm_pkg::FULL_LEN_HK_RST;
    end else if (cfg_write) begin
      case (sghm_pkg::reg_index_t'(cfg_index))
        sghm_pkg::REG_FULL_LEN_SCIENCE: full_len_science <= cfg_data;
        sghm_pkg::REG_FULL_LEN_HK:      full_len_hk <= cfg_data;
        default:                        full_len_hk <= full_len_hk;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STREAM_COUNT; i++) begin
        seen[i]      <= 1'b0;
        first_seq[i] <= '0;
        last_seq[i]  <= '0;
        rollover[i]  <= '0;
        full_cnt[i]  <= '0;
        fill_cnt[i]  <= '0;
      end
    end else if (rec) begin
      if (count_full && (full_cnt[cls_idx] != '1)) begin
        full_cnt[cls_idx] <= full_cnt[cls_idx] + NB'(1);
      end
      if (count_fill && (fill_cnt[cls_idx] != '1)) begin
        fill_cnt[cls_idx] <= fill_cnt[cls_idx] + NB'(1);
      end
      if (first) begin
        seen[cls_idx]      <= 1'b1;
        first_seq[cls_idx] <= seq;
      end else if (prev_last > seq) begin
        rollover[cls_idx] <= roll_sum[NB] ? '1 : roll_sum[NB-1:0];
      end
      last_seq[cls_idx] <= seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign bin_old = (wb_valid && (wb_addr == s1.addr)) ? wb_data : ram_rdata;
  assign bin_sum = {1'b0, bin_old} + (NB+1)'(s1.gap);

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1.valid && s1.bin_write;
      ram_waddr = s1.addr;
      ram_wdata = bin_sum[NB] ? '1 : bin_sum[NB-1:0];
    end
  end

  sghm_ram #(
    .WIDTH(NB),
    .DEPTH(DEPTH)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      wb_valid <= 1'b0;
    end else begin
      s1       <= s1_next;
      wb_valid <= ram_we;
    end
    wb_addr <= ram_waddr;
    wb_data <= ram_wdata;
  end

  always_comb begin
    s1_result = '0;
    s1_result.first_seen     = s1.first_seen;
    s1_result.gap_found      = s1.gap_found;
    s1_result.gap_length     = s1.gap;
    s1_result.large_gap      = s1.large_gap;
    s1_result.bin_total      = s1.bin_read ? bin_old : '0;
    s1_result.full_count     = s1.full_count;
    s1_result.fill_count     = s1.fill_count;
    s1_result.expected_count = s1.expected_count;
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1.valid) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      count <= count + (QW+1)'(s1.valid) - (QW+1)'(pop);
    end
    if (s1.valid) begin
      fifo[wr_ptr] <= s1_result;
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {{PAD{1'b0}}, fifo[rd_ptr]};

endmodule

>>> rtl/core/sghm_ram.sv
module sghm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
